// ----- design/chacha_pkg.sv -----
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types and constants for the ChaCha20 byte-stream cipher core:
// beat layouts, register indexes, block constants and sequencer states.
// ----------------------------------------------------------------------------
package chacha_pkg;

  // Beat layouts on the two streaming channels
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_beat_t;

  // Configuration port geometry
  localparam int CFG_WIDTH   = 64;
  localparam int CFG_INDEX_W = 3;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART_0    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART_1    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART_2    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_KEY_PART_3    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_NONCE_LOW     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_NONCE_HIGH    = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_START_COUNTER = 3'd6;

  // "expand 32-byte k"
  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  // Quarter-round rotate amounts, one per half step
  localparam int ROT_0 = 16;
  localparam int ROT_1 = 12;
  localparam int ROT_2 = 8;
  localparam int ROT_3 = 7;

  // Working state: sixteen 32-bit words
  typedef logic [15:0][31:0] block_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

endpackage

// ----- design/chacha20_stream_cipher_core.sv -----
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core
// ChaCha20 (20-round, 96-bit nonce) keystream generator applied one byte per
// beat. One shared add/xor/rotate unit runs the quarter rounds under a small
// sequencer; the working state doubles as the 64-byte keystream buffer.
// ----------------------------------------------------------------------------
//
//  channel | signals                          | direction | beat
//  --------+----------------------------------+-----------+---------------------
//  cfg     | cfg_write cfg_index cfg_data     | in        | one register write
//  in      | in_valid in_ready in_data        | in        | data byte + last
//  out     | out_valid out_ready out_data     | out       | xored byte + last
//
//  A byte whose keystream block is already made is taken and its result
//  registered the next edge, so a block's bytes 1..63 run one per cycle while
//  the output is not stalled. The first byte of a block waits for one load,
//  32 half steps per double round on the shared adder, 16 feed-forward adds
//  on the same adder path, and one emit.
//  A stalled output register holds the result and keeps in_ready low.
//  rst (synchronous) clears the configuration registers, the sequencer, the position and the block count.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_core #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [chacha_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [chacha_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  chacha_pkg::in_beat_t                 in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output chacha_pkg::out_beat_t                out_data
);
  import chacha_pkg::*;

  localparam int DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
  localparam logic [DR_W-1:0] DR_LAST = DR_W'(DOUBLE_ROUNDS - 1);

  // Configuration registers
  logic [63:0] key_part_0, key_part_1, key_part_2, key_part_3;
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;
  logic [31:0] start_counter;

  // Stream position state
  logic [5:0]  byte_pos;
  logic [31:0] block_count;
  logic        keystream_ready;

  // Sequencer
  state_t      state, state_next;
  logic [4:0]  rcnt;        // [1:0] half step, [3:2] quarter round, [4] diagonal pass
  logic [DR_W-1:0] dr;
  logic [3:0]  fin_cnt;

  // Working state / keystream block and held input beat
  block_t      w;
  block_t      init_words;
  block_t      round_next;
  block_t      final_next;
  logic [31:0] add_out;
  in_beat_t    held;

  // Control
  logic        out_free;
  logic        load;
  logic        emit;
  logic        cfg_hit;

  assign out_free = !out_valid || out_ready;
  assign cfg_hit  = cfg_write && (cfg_index <= REG_START_COUNTER);

  // Block function input state
  always_comb begin
    init_words[0]  = SIGMA_0;
    init_words[1]  = SIGMA_1;
    init_words[2]  = SIGMA_2;
    init_words[3]  = SIGMA_3;
    init_words[4]  = key_part_0[31:0];
    init_words[5]  = key_part_0[63:32];
    init_words[6]  = key_part_1[31:0];
    init_words[7]  = key_part_1[63:32];
    init_words[8]  = key_part_2[31:0];
    init_words[9]  = key_part_2[63:32];
    init_words[10] = key_part_3[31:0];
    init_words[11] = key_part_3[63:32];
    init_words[12] = block_count;
    init_words[13] = nonce_low[31:0];
    init_words[14] = nonce_low[63:32];
    init_words[15] = nonce_high;
  end

  // Rotate each row left by its own amount: new[4r+j] = old[4r+(j+amt[r])%4]
  function automatic block_t row_rotate(input block_t b, input logic [3:0][1:0] amt);
    block_t     o;
    logic [1:0] idx;
    for (int r = 0; r < 4; r++) begin
      for (int j = 0; j < 4; j++) begin
        idx = 2'(j) + amt[r];
        o[4*r+j] = b[4*r+idx];
      end
    end
    return o;
  endfunction

  // Shared half-quarter-round unit, always working on column 0 (words 0,4,8,12).
  // Even steps: a += b, d = (d ^ a) <<< n. Odd steps: c += d, b = (b ^ c) <<< n.
  // After the last step of a quarter round the rows rotate to bring up the
  // next column; the fourth quarter round also (un)diagonalizes the state.
  // During feed-forward the same adder adds the input word to w[0].
  always_comb begin
    logic [31:0]      p, q, r, sum, x, mixed;
    block_t           stepped;
    logic [3:0][1:0]  amt;
    p   = (state == ST_ROUND && rcnt[0]) ? w[8] : w[0];
    q   = (state == ST_FINAL) ? init_words[fin_cnt] : (rcnt[0] ? w[12] : w[4]);
    r   = rcnt[0] ? w[4]  : w[12];
    sum = p + q;
    add_out = sum;
    x   = r ^ sum;
    case (rcnt[1:0])
      2'd0:    mixed = (x << ROT_0) | (x >> (32 - ROT_0));
      2'd1:    mixed = (x << ROT_1) | (x >> (32 - ROT_1));
      2'd2:    mixed = (x << ROT_2) | (x >> (32 - ROT_2));
      default: mixed = (x << ROT_3) | (x >> (32 - ROT_3));
    endcase
    stepped = w;
    if (rcnt[0]) begin
      stepped[8] = sum;
      stepped[4] = mixed;
    end else begin
      stepped[0]  = sum;
      stepped[12] = mixed;
    end
    for (int k = 0; k < 4; k++) begin
      if (rcnt[1:0] != 2'd3) begin
        amt[k] = 2'd0;
      end else if (rcnt[3:2] != 2'd3) begin
        amt[k] = 2'd1;
      end else if (!rcnt[4]) begin
        amt[k] = 2'(1 + k);     // end of column pass: diagonalize
      end else begin
        amt[k] = 2'(1 - k);     // end of diagonal pass: restore
      end
    end
    round_next = row_rotate(stepped, amt);
  end

  // Feed-forward: shift the words down, adding the input word at the tail
  always_comb begin
    for (int i = 0; i < 15; i++) begin
      final_next[i] = w[i+1];
    end
    final_next[15] = add_out;
  end

  // Result of the beat being emitted
  in_beat_t    src;
  logic [31:0] ks_word;
  logic [7:0]  ks_byte;
  out_beat_t   result;

  always_comb begin
    src            = (state == ST_EMIT) ? held : in_data;
    ks_word        = w[byte_pos[5:2]];
    ks_byte        = ks_word[{byte_pos[1:0], 3'b000} +: 8];
    result.out_byte = src.data_byte ^ ks_byte;
    result.out_last = src.end_of_message;
  end

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load       = 1'b0;
    emit       = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          if (keystream_ready) begin
            emit = 1'b1;
          end else begin
            load       = 1'b1;
            state_next = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        if (rcnt == 5'd31 && dr == DR_LAST) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (fin_cnt == 4'd15) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Round and feed-forward counters
  always_ff @(posedge clk) begin
    if (rst) begin
      rcnt    <= '0;
      dr      <= '0;
      fin_cnt <= '0;
    end else if (load) begin
      rcnt    <= '0;
      dr      <= '0;
      fin_cnt <= '0;
    end else if (state == ST_ROUND) begin
      rcnt <= rcnt + 5'd1;
      if (rcnt == 5'd31) begin
        dr <= dr + DR_W'(1);
      end
    end else if (state == ST_FINAL) begin
      fin_cnt <= fin_cnt + 4'd1;
    end
  end

  // Working state and held beat
  always_ff @(posedge clk) begin
    if (load) begin
      w    <= init_words;
      held <= in_data;
    end else if (state == ST_ROUND) begin
      w <= round_next;
    end else if (state == ST_FINAL) begin
      w <= final_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_part_0    <= '0;
      key_part_1    <= '0;
      key_part_2    <= '0;
      key_part_3    <= '0;
      nonce_low     <= '0;
      nonce_high    <= '0;
      start_counter <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_PART_0:    key_part_0    <= cfg_data;
        REG_KEY_PART_1:    key_part_1    <= cfg_data;
        REG_KEY_PART_2:    key_part_2    <= cfg_data;
        REG_KEY_PART_3:    key_part_3    <= cfg_data;
        REG_NONCE_LOW:     nonce_low     <= cfg_data;
        REG_NONCE_HIGH:    nonce_high    <= cfg_data[31:0];
        REG_START_COUNTER: start_counter <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Stream position: restart on config write or end of message,
  // advance the block counter after byte 63
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos        <= '0;
      block_count     <= '0;
      keystream_ready <= 1'b0;
    end else if (cfg_hit) begin
      byte_pos        <= '0;
      block_count     <= (cfg_index == REG_START_COUNTER) ? cfg_data[31:0] : start_counter;
      keystream_ready <= 1'b0;
    end else if (emit) begin
      if (src.end_of_message) begin
        byte_pos        <= '0;
        block_count     <= start_counter;
        keystream_ready <= 1'b0;
      end else begin
        byte_pos <= byte_pos + 6'd1;
        if (byte_pos == 6'd63) begin
          block_count     <= block_count + 32'd1;
          keystream_ready <= 1'b0;
        end
      end
    end else if (state == ST_FINAL && fin_cnt == 4'd15) begin
      keystream_ready <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

  // Checks
  a_miss_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !keystream_ready) |=> (state == ST_ROUND))
    else $error("block generation did not start on a keystream miss");

  a_hit_gives_beat: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && keystream_ready) |=> out_valid)
    else $error("accepted beat with ready keystream produced no result");

  a_emit_has_keystream: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> keystream_ready)
    else $error("emitting without a finished keystream block");

  a_pos_needs_block: assert property (@(posedge clk) disable iff (rst)
    (byte_pos != 6'd0) |-> keystream_ready)
    else $error("byte position advanced without a keystream block");

  a_final_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINAL && fin_cnt == 4'd15 && !cfg_hit) |=> keystream_ready)
    else $error("feed-forward finished but keystream not marked ready");

endmodule
